/* rtl/zmb_pkg.sv */
package zmb_pkg;

  localparam int MAX_WIDTH     = 256;
  localparam int MAX_HEIGHT    = 256;
  localparam int NOMINAL_STEPS = 100;
  localparam int MAX_STEPS     = 200;
  localparam int MIN_STEPS     = 3;
  localparam int CORNERS       = 4;
  localparam int COL_W         = $clog2(MAX_WIDTH);
  localparam int ROW_W         = $clog2(MAX_HEIGHT);
  localparam int ADDR_W        = COL_W + ROW_W;

  localparam logic [2:0] REG_CENTER_COL   = 3'd0;
  localparam logic [2:0] REG_CENTER_ROW   = 3'd1;
  localparam logic [2:0] REG_BLUR_FACTOR  = 3'd2;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd3;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd4;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic [15:0] alpha_in;
  } in_word_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic [15:0] alpha_out;
  } out_word_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [7:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [7:0]  remainder;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_VECX,
    ST_VECY,
    ST_VECD,
    ST_SQX,
    ST_SQY,
    ST_ROOT1_GO,
    ST_ROOT1_WAIT,
    ST_STEPS,
    ST_CHECK,
    ST_ROOT2_GO,
    ST_ROOT2_WAIT,
    ST_DIVX_GO,
    ST_DIVX_WAIT,
    ST_DIVY_GO,
    ST_DIVY_WAIT,
    ST_SAMPLE,
    ST_DRAIN,
    ST_DIVC_GO,
    ST_DIVC_WAIT,
    ST_FINISH
  } state_t;

endpackage

/* rtl/zoom_motion_blur.sv */
// Zoom motion blur. A load word is written to the store and busy stays low.
// A query walks n steps, n being the step count (3 to 200), and takes a second root
// when n passes 100; busy drops the cycle after done. The four corners of each step
// are fetched through the store's one read port, and each use of the shared root unit
// or divider is started and then waited on until its done.
// The result shows for one cycle with done, no stall; synchronous reset keeps the store.
module zoom_motion_blur (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  zmb_pkg::in_word_t  item,
  output logic               done,
  output zmb_pkg::out_word_t result,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data
);

  // Configuration registers.
  logic [12:0]        center_col;
  logic [12:0]        center_row;
  logic signed [16:0] blur_factor;
  logic [8:0]         image_width;
  logic [8:0]         image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_col   <= 13'd2048;
      center_row   <= 13'd2048;
      blur_factor  <= 17'sd410;
      image_width  <= 9'd256;
      image_height <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        zmb_pkg::REG_CENTER_COL:   center_col   <= cfg_data[12:0];
        zmb_pkg::REG_CENTER_ROW:   center_row   <= cfg_data[12:0];
        zmb_pkg::REG_BLUR_FACTOR:  blur_factor  <= $signed(cfg_data);
        zmb_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[8:0];
        zmb_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  zmb_pkg::state_t state, state_next;

  logic [7:0]         q_col;
  logic [7:0]         q_row;
  logic signed [42:0] vprod;
  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic [63:0]        sqacc;
  logic [31:0]        len;
  logic [16:0]        n17;
  logic [7:0]         n8;
  logic signed [31:0] sx;
  logic signed [31:0] sy;
  logic signed [39:0] cx;
  logic signed [39:0] cy;
  logic [7:0]         step;
  logic [1:0]         corner;
  logic [1:0]         drain;
  logic [1:0]         ch;
  zmb_pkg::out_word_t res_word;

  zmb_pkg::div_req_t  div_req;
  zmb_pkg::div_rsp_t  div_rsp;
  zmb_pkg::sqrt_req_t sqrt_req;
  zmb_pkg::sqrt_rsp_t sqrt_rsp;

  zmb_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));
  zmb_sqrt u_sqrt (.clk(clk), .rst(rst), .req(sqrt_req), .rsp(sqrt_rsp));

  // Store ports. A load writes while the sequencer is idle.
  logic                       store_we;
  logic [zmb_pkg::ADDR_W-1:0] raddr;
  logic [63:0]                rdata;

  assign store_we = start && !busy && (item.kind == zmb_pkg::KIND_LOAD);

  zmb_store u_store (
    .clk  (clk),
    .we   (store_we),
    .waddr({item.row, item.col}),
    .wdata({item.alpha_in, item.blue_in, item.green_in, item.red_in}),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Walk vector: (center << 12) - (pos << 16), times the factor, floored by 2^12.
  logic signed [25:0] diff_x;
  logic signed [25:0] diff_y;
  logic signed [25:0] diff_sel;
  logic signed [42:0] v_mult;

  assign diff_x   = $signed({1'b0, center_col, 12'b0}) - $signed({2'b0, q_col, 16'b0});
  assign diff_y   = $signed({1'b0, center_row, 12'b0}) - $signed({2'b0, q_row, 16'b0});
  assign diff_sel = (state == zmb_pkg::ST_VECX) ? diff_x : diff_y;
  assign v_mult   = diff_sel * blur_factor;

  // Squared length, one axis per cycle through one multiplier.
  logic signed [31:0] dsq;
  logic signed [63:0] sq_prod;

  assign dsq     = (state == zmb_pkg::ST_SQX) ? dx : dy;
  assign sq_prod = dsq * dsq;

  // Step count before the soft limit: ceil((len + 1.0) / 1.0) in pixel units.
  logic [32:0] len_up;
  logic [16:0] n_raw;
  logic [9:0]  n_soft;

  assign len_up = {1'b0, len} + 33'd131071;
  assign n_raw  = len_up[32:16];
  assign n_soft = 10'(zmb_pkg::NOMINAL_STEPS) + {1'b0, sqrt_rsp.root[8:0]};

  // Floor division of a walk component by n, from the magnitude quotient.
  logic        div_neg;
  logic [31:0] div_abs;
  logic [31:0] div_floor;

  assign div_neg   = (state == zmb_pkg::ST_DIVX_GO) ? dx[31] : dy[31];
  assign div_abs   = div_neg ? ((state == zmb_pkg::ST_DIVX_GO) ? -dx : -dy)
                             : ((state == zmb_pkg::ST_DIVX_GO) ? dx : dy);
  assign div_floor = (state == zmb_pkg::ST_DIVX_WAIT ? dx[31] : dy[31])
                   ? (~div_rsp.quotient + {31'b0, div_rsp.remainder == 8'd0})
                   : div_rsp.quotient;

  // Sample fetch: corner bit 0 steps the column, bit 1 the row.
  logic signed [24:0] col_k;
  logic signed [24:0] row_k;
  logic [8:0]         wlim;
  logic [8:0]         hlim;
  logic               inb;
  logic [16:0]        wx;
  logic [16:0]        wy;
  logic [33:0]        weight;

  assign wlim  = (image_width > 9'(zmb_pkg::MAX_WIDTH)) ? 9'(zmb_pkg::MAX_WIDTH) : image_width;
  assign hlim  = (image_height > 9'(zmb_pkg::MAX_HEIGHT)) ? 9'(zmb_pkg::MAX_HEIGHT)
                                                          : image_height;
  assign col_k = $signed({cx[39], cx[39:16]}) + $signed({24'b0, corner[0]});
  assign row_k = $signed({cy[39], cy[39:16]}) + $signed({24'b0, corner[1]});
  assign inb   = !col_k[24] && !row_k[24]
              && (col_k < $signed({16'b0, wlim})) && (row_k < $signed({16'b0, hlim}));
  assign raddr = {row_k[zmb_pkg::ROW_W-1:0], col_k[zmb_pkg::COL_W-1:0]};
  assign wx    = corner[0] ? {1'b0, cx[15:0]} : (17'h10000 - {1'b0, cx[15:0]});
  assign wy    = corner[1] ? {1'b0, cy[15:0]} : (17'h10000 - {1'b0, cy[15:0]});
  assign weight = wx * wy;

  // Sample pipeline: weight and store word, then products, then accumulation.
  logic        p1_valid;
  logic        p1_inb;
  logic [33:0] p1_w;
  logic        p2_valid;
  logic [49:0] prod [zmb_pkg::CORNERS];
  logic [55:0] acc  [zmb_pkg::CORNERS];
  logic        acc_clear;

  assign acc_clear = (state == zmb_pkg::ST_DIVY_WAIT) && div_rsp.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= (state == zmb_pkg::ST_SAMPLE);
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    p1_inb <= inb;
    p1_w   <= weight;
    for (int c = 0; c < zmb_pkg::CORNERS; c++) begin
      prod[c] <= p1_inb ? (p1_w * rdata[16*c +: 16]) : '0;
      if (acc_clear) begin
        acc[c] <= '0;
      end else if (p2_valid) begin
        acc[c] <= acc[c] + {6'b0, prod[c]};
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= zmb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next        = state;
    div_req.start     = 1'b0;
    div_req.dividend  = div_abs;
    div_req.divisor   = n8;
    sqrt_req.start    = 1'b0;
    sqrt_req.radicand = sqacc;
    case (state)
      zmb_pkg::ST_IDLE: begin
        if (start && item.kind == zmb_pkg::KIND_QUERY) begin
          state_next = zmb_pkg::ST_VECX;
        end
      end
      zmb_pkg::ST_VECX:     state_next = zmb_pkg::ST_VECY;
      zmb_pkg::ST_VECY:     state_next = zmb_pkg::ST_VECD;
      zmb_pkg::ST_VECD:     state_next = zmb_pkg::ST_SQX;
      zmb_pkg::ST_SQX:      state_next = zmb_pkg::ST_SQY;
      zmb_pkg::ST_SQY:      state_next = zmb_pkg::ST_ROOT1_GO;
      zmb_pkg::ST_ROOT1_GO: begin
        sqrt_req.start = 1'b1;
        state_next     = zmb_pkg::ST_ROOT1_WAIT;
      end
      zmb_pkg::ST_ROOT1_WAIT: begin
        if (sqrt_rsp.done) begin
          state_next = zmb_pkg::ST_STEPS;
        end
      end
      zmb_pkg::ST_STEPS:    state_next = zmb_pkg::ST_CHECK;
      zmb_pkg::ST_CHECK: begin
        state_next = (n17 > 17'(zmb_pkg::NOMINAL_STEPS)) ? zmb_pkg::ST_ROOT2_GO
                                                         : zmb_pkg::ST_DIVX_GO;
      end
      zmb_pkg::ST_ROOT2_GO: begin
        sqrt_req.start    = 1'b1;
        sqrt_req.radicand = {47'b0, n17 - 17'(zmb_pkg::NOMINAL_STEPS)};
        state_next        = zmb_pkg::ST_ROOT2_WAIT;
      end
      zmb_pkg::ST_ROOT2_WAIT: begin
        if (sqrt_rsp.done) begin
          state_next = zmb_pkg::ST_DIVX_GO;
        end
      end
      zmb_pkg::ST_DIVX_GO: begin
        div_req.start = 1'b1;
        state_next    = zmb_pkg::ST_DIVX_WAIT;
      end
      zmb_pkg::ST_DIVX_WAIT: begin
        if (div_rsp.done) begin
          state_next = zmb_pkg::ST_DIVY_GO;
        end
      end
      zmb_pkg::ST_DIVY_GO: begin
        div_req.start = 1'b1;
        state_next    = zmb_pkg::ST_DIVY_WAIT;
      end
      zmb_pkg::ST_DIVY_WAIT: begin
        if (div_rsp.done) begin
          state_next = zmb_pkg::ST_SAMPLE;
        end
      end
      zmb_pkg::ST_SAMPLE: begin
        if (corner == 2'd3 && step == n8 - 8'd1) begin
          state_next = zmb_pkg::ST_DRAIN;
        end
      end
      zmb_pkg::ST_DRAIN: begin
        if (drain == 2'd2) begin
          state_next = zmb_pkg::ST_DIVC_GO;
        end
      end
      zmb_pkg::ST_DIVC_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {8'b0, acc[ch][55:32]};
        state_next       = zmb_pkg::ST_DIVC_WAIT;
      end
      zmb_pkg::ST_DIVC_WAIT: begin
        if (div_rsp.done) begin
          state_next = (ch == 2'd3) ? zmb_pkg::ST_FINISH : zmb_pkg::ST_DIVC_GO;
        end
      end
      zmb_pkg::ST_FINISH:   state_next = zmb_pkg::ST_IDLE;
      default:              state_next = zmb_pkg::ST_IDLE;
    endcase
  end

  // Datapath registers loaded by the sequencer.
  always_ff @(posedge clk) begin
    case (state)
      zmb_pkg::ST_IDLE: begin
        q_col <= item.col;
        q_row <= item.row;
      end
      zmb_pkg::ST_VECX: vprod <= v_mult;
      zmb_pkg::ST_VECY: begin
        dx    <= {vprod[42], vprod[42:12]};
        vprod <= v_mult;
      end
      zmb_pkg::ST_VECD: dy <= {vprod[42], vprod[42:12]};
      zmb_pkg::ST_SQX:  sqacc <= sq_prod;
      zmb_pkg::ST_SQY:  sqacc <= sqacc + sq_prod;
      zmb_pkg::ST_ROOT1_WAIT: begin
        if (sqrt_rsp.done) begin
          len <= sqrt_rsp.root;
        end
      end
      zmb_pkg::ST_STEPS: begin
        n17 <= (n_raw < 17'(zmb_pkg::MIN_STEPS)) ? 17'(zmb_pkg::MIN_STEPS) : n_raw;
      end
      zmb_pkg::ST_CHECK: n8 <= n17[7:0];
      zmb_pkg::ST_ROOT2_WAIT: begin
        if (sqrt_rsp.done) begin
          n8 <= (n_soft > 10'(zmb_pkg::MAX_STEPS)) ? 8'(zmb_pkg::MAX_STEPS) : n_soft[7:0];
        end
      end
      zmb_pkg::ST_DIVX_WAIT: begin
        if (div_rsp.done) begin
          sx <= div_floor;
        end
      end
      zmb_pkg::ST_DIVY_WAIT: begin
        if (div_rsp.done) begin
          sy     <= div_floor;
          cx     <= $signed({16'b0, q_col, 16'b0});
          cy     <= $signed({16'b0, q_row, 16'b0});
          step   <= '0;
          corner <= '0;
          drain  <= '0;
          ch     <= '0;
        end
      end
      zmb_pkg::ST_SAMPLE: begin
        corner <= corner + 2'd1;
        if (corner == 2'd3) begin
          cx   <= cx + {{8{sx[31]}}, sx};
          cy   <= cy + {{8{sy[31]}}, sy};
          step <= step + 8'd1;
        end
      end
      zmb_pkg::ST_DRAIN: drain <= drain + 2'd1;
      zmb_pkg::ST_DIVC_WAIT: begin
        if (div_rsp.done) begin
          case (ch)
            2'd0:    res_word.red_out   <= div_rsp.quotient[15:0];
            2'd1:    res_word.green_out <= div_rsp.quotient[15:0];
            2'd2:    res_word.blue_out  <= div_rsp.quotient[15:0];
            default: res_word.alpha_out <= div_rsp.quotient[15:0];
          endcase
          ch <= ch + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // The word stays in its register; done is high for one cycle once it is complete.
  assign busy   = (state != zmb_pkg::ST_IDLE);
  assign done   = (state == zmb_pkg::ST_FINISH);
  assign result = res_word;

endmodule

/* rtl/zmb_div.sv */
// Restoring divider, one quotient bit per cycle.
module zmb_div (
  input  logic               clk,
  input  logic               rst,
  input  zmb_pkg::div_req_t  req,
  output zmb_pkg::div_rsp_t  rsp
);

  logic        running;
  logic        done;
  logic [4:0]  cnt;
  logic [31:0] dq;
  logic [7:0]  rem;
  logic [7:0]  dsr;
  logic [8:0]  trial;
  logic [8:0]  diff;
  logic        ge;

  always_comb begin
    trial = {rem, dq[31]};
    diff  = trial - {1'b0, dsr};
    ge    = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= '0;
        dq      <= req.dividend;
        rem     <= '0;
        dsr     <= req.divisor;
      end else if (running) begin
        dq  <= {dq[30:0], ge};
        rem <= ge ? diff[7:0] : trial[7:0];
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = dq;
  assign rsp.remainder = rem;

endmodule

/* rtl/zmb_sqrt.sv */
// Digit-by-digit integer square root, one result bit per cycle.
module zmb_sqrt (
  input  logic                clk,
  input  logic                rst,
  input  zmb_pkg::sqrt_req_t  req,
  output zmb_pkg::sqrt_rsp_t  rsp
);

  logic        running;
  logic        done;
  logic [4:0]  cnt;
  logic [63:0] v;
  logic [63:0] res;
  logic [63:0] probe;
  logic [63:0] trial;
  logic        ge;

  always_comb begin
    trial = res + probe;
    ge    = v >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= '0;
        v       <= req.radicand;
        res     <= '0;
        probe   <= 64'h4000_0000_0000_0000;
      end else if (running) begin
        if (ge) begin
          v   <= v - trial;
          res <= (res >> 1) + probe;
        end else begin
          res <= res >> 1;
        end
        probe <= probe >> 2;
        cnt   <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.root = res[31:0];

endmodule

/* rtl/zmb_store.sv */
// Image store: one write port, one registered read port.
module zmb_store (
  input  logic                        clk,
  input  logic                        we,
  input  logic [zmb_pkg::ADDR_W-1:0]  waddr,
  input  logic [63:0]                 wdata,
  input  logic [zmb_pkg::ADDR_W-1:0]  raddr,
  output logic [63:0]                 rdata
);

  logic [63:0] mem [2**zmb_pkg::ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
